### rtl/core/srtr_pkg.sv
// ----------------------------------------------------------------------------
// srtr_pkg: shared types and constants for the sentence break text reflow
// Character codes, the one-hot reflow state type and the burst record that
// carries up to three bytes from the state machine to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package srtr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned BURST_N = 3;

	localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_PERIOD = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_QUEST  = 8'h3F;
	localparam logic [BYTE_W-1:0] CHAR_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_SEMI   = 8'h3B;
	localparam logic [BYTE_W-1:0] CHAR_LPAREN = 8'h28;
	localparam logic [BYTE_W-1:0] CHAR_RPAREN = 8'h29;
	localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9      = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_LA     = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LZ     = 8'h7A;
	localparam logic [BYTE_W-1:0] CHAR_UA     = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UZ     = 8'h5A;

	// Reflow state, one-hot.
	typedef enum logic [6:0] {
		M_PLAIN    = 7'b0000001,
		M_PUNCT    = 7'b0000010,
		M_PUNCT_SP = 7'b0000100,
		M_PAREN    = 7'b0001000,
		M_PAREN_SP = 7'b0010000,
		M_SPACE    = 7'b0100000,
		M_SPACE_OP = 7'b1000000
	} mode_t;

	// Bytes produced by one input byte; element 0 goes out first.
	typedef struct packed {
		logic [1:0]                          count;
		logic [BURST_N-1:0][BYTE_W-1:0]      bytes;
	} burst_t;

	function automatic logic is_punct(input logic [BYTE_W-1:0] c);
		return (c == CHAR_PERIOD) || (c == CHAR_QUEST) ||
			(c == CHAR_COLON) || (c == CHAR_SEMI);
	endfunction

	function automatic logic is_digit_or_lower(input logic [BYTE_W-1:0] c);
		return ((c >= CHAR_0) && (c <= CHAR_9)) || ((c >= CHAR_LA) && (c <= CHAR_LZ));
	endfunction

	function automatic logic is_upper(input logic [BYTE_W-1:0] c);
		return (c >= CHAR_UA) && (c <= CHAR_UZ);
	endfunction

endpackage

`default_nettype wire

### rtl/core/sentence_break_text_reflow.sv
// ----------------------------------------------------------------------------
// sentence_break_text_reflow: byte stream reflow at sentence breaks
// Collapses runs of spaces and turns held spaces after sentence punctuation
// or parentheses into newlines, one input byte to zero..three output bytes.
// ----------------------------------------------------------------------------
// Each input byte is taken into an input register, decoded against the
// reflow state in a single pass, and its zero to three output bytes are
// loaded into a result register that hands them out one per transfer, with
// last_of_run set on the final byte of each input. A space after text,
// punctuation or a closing parenthesis is held back, as is an opening
// parenthesis that follows such a space; such held bytes are released, or
// rewritten as a newline, only when the next input byte is seen, and bytes
// still held when the stream stops are never sent. The first byte of an
// input is presented once its burst has passed from the input register
// into the result register. A new input byte is taken in every cycle as
// long as the output side keeps up; when an input gives more than one byte,
// the next burst waits in the input register until the last byte leaves the
// result register, which sends one byte per transfer. There are no
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sentence_break_text_reflow (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [srtr_pkg::BYTE_W-1:0] in_byte,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [srtr_pkg::BYTE_W-1:0] out_byte,
	output logic                        last_of_run
);
	import srtr_pkg::*;

	// Burst handoff between the state machine and the result register.
	logic   burst_valid;
	logic   burst_ready;
	burst_t burst;

	srtr_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_ready (burst_ready)
	);

	srtr_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst_ready (burst_ready),
		.burst       (burst),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

### rtl/core/srtr_fsm.sv
// ----------------------------------------------------------------------------
// srtr_fsm: input register and reflow state machine
// Holds one input byte, decodes it against the current state into a burst
// of zero to three output bytes and advances the state when the burst is
// handed to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srtr_fsm (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [srtr_pkg::BYTE_W-1:0] in_byte,
	output logic                        burst_valid,
	output srtr_pkg::burst_t            burst,
	input  wire logic                   burst_ready
);
	import srtr_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	mode_t             mode_q;
	mode_t             mode_next;
	logic              advance;
	logic              c_punct;
	logic              c_dl;
	logic              c_up;
	logic              c_space;
	logic              c_lp;
	logic              c_rp;

	assign advance     = valid_s1 && burst_ready;
	assign in_ready    = !valid_s1 || burst_ready;
	assign burst_valid = valid_s1;

	assign c_punct = is_punct(byte_s1);
	assign c_dl    = is_digit_or_lower(byte_s1);
	assign c_up    = is_upper(byte_s1);
	assign c_space = (byte_s1 == CHAR_SPACE);
	assign c_lp    = (byte_s1 == CHAR_LPAREN);
	assign c_rp    = (byte_s1 == CHAR_RPAREN);

	always_comb begin
		burst.count    = 2'd0;
		burst.bytes[0] = CHAR_NUL;
		burst.bytes[1] = CHAR_NUL;
		burst.bytes[2] = CHAR_NUL;
		mode_next      = mode_q;
		unique case (mode_q)
			M_PUNCT: begin
				priority if (c_punct) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1;
				end else if (c_space) begin
					mode_next = M_PUNCT_SP;
				end else if (c_rp) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PAREN;
				end else begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PLAIN;
				end
			end
			M_PUNCT_SP: begin
				priority if (c_punct) begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PUNCT;
				end else if (c_space) begin
					mode_next = M_PUNCT_SP;
				end else if (c_lp) begin
					mode_next = M_SPACE_OP;
				end else if (c_rp) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PAREN;
				end else begin
					burst.count = 2'd2; burst.bytes[0] = c_dl ? CHAR_NL : CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PLAIN;
				end
			end
			M_PAREN: begin
				priority if (c_punct) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PUNCT;
				end else if (c_space) begin
					mode_next = M_PAREN_SP;
				end else if (c_rp) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1;
				end else begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PLAIN;
				end
			end
			M_PAREN_SP: begin
				priority if (c_punct) begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PUNCT;
				end else if (c_space) begin
					mode_next = M_PAREN_SP;
				end else if (c_lp) begin
					mode_next = M_SPACE_OP;
				end else if (c_rp) begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PAREN;
				end else begin
					burst.count = 2'd2; burst.bytes[0] = c_up ? CHAR_NL : CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PLAIN;
				end
			end
			M_SPACE: begin
				priority if (c_punct) begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PUNCT;
				end else if (c_space) begin
					mode_next = M_SPACE;
				end else if (c_lp) begin
					mode_next = M_SPACE_OP;
				end else if (c_rp) begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PAREN;
				end else begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = byte_s1; mode_next = M_PLAIN;
				end
			end
			M_SPACE_OP: begin
				priority if (c_punct) begin
					burst.count = 2'd3; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = CHAR_LPAREN; burst.bytes[2] = byte_s1;
					mode_next = M_PUNCT;
				end else if (c_space) begin
					burst.count = 2'd2; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = CHAR_LPAREN; mode_next = M_SPACE;
				end else if (c_lp || c_rp) begin
					burst.count = 2'd3; burst.bytes[0] = CHAR_SPACE;
					burst.bytes[1] = CHAR_LPAREN; burst.bytes[2] = byte_s1;
					mode_next = M_PLAIN;
				end else begin
					burst.count = 2'd3; burst.bytes[0] = c_up ? CHAR_NL : CHAR_SPACE;
					burst.bytes[1] = CHAR_LPAREN; burst.bytes[2] = byte_s1;
					mode_next = M_PLAIN;
				end
			end
			default: begin
				// Plain text; any code outside the state set behaves the same.
				priority if (c_punct) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PUNCT;
				end else if (c_space) begin
					mode_next = M_SPACE;
				end else if (c_rp) begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PAREN;
				end else begin
					burst.count = 2'd1; burst.bytes[0] = byte_s1; mode_next = M_PLAIN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_PLAIN;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q <= mode_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q))
		else $error("reflow state is not one-hot");

	a_three_only_after_open: assert property (@(posedge clk) disable iff (!arst_n)
		(burst_valid && burst.count == 2'd3) |-> (mode_q == M_SPACE_OP))
		else $error("three-byte burst outside held space-paren state");

	a_space_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && c_space) |=>
		(mode_q == M_SPACE || mode_q == M_PUNCT_SP || mode_q == M_PAREN_SP))
		else $error("a space did not leave a held-space state");

endmodule

`default_nettype wire

### rtl/core/srtr_serializer.sv
// ----------------------------------------------------------------------------
// srtr_serializer: result register and byte serializer
// Holds one burst and presents its bytes one per transfer, marking the last
// byte of the burst. Takes the next burst when empty or as the last byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module srtr_serializer (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   burst_valid,
	output logic                        burst_ready,
	input  wire srtr_pkg::burst_t       burst,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [srtr_pkg::BYTE_W-1:0] out_byte,
	output logic                        last_of_run
);
	import srtr_pkg::*;

	logic [BURST_N-1:0][BYTE_W-1:0] bytes_q;
	logic [1:0]                     left_q;
	logic                           load;
	logic                           send;

	assign out_valid   = (left_q != 2'd0);
	assign last_of_run = (left_q == 2'd1);
	assign out_byte    = bytes_q[0];
	assign send        = out_valid && out_ready;
	assign burst_ready = !out_valid || (last_of_run && out_ready);
	assign load        = burst_valid && burst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
		end else if (load) begin
			left_q <= burst.count;
		end else if (send) begin
			left_q <= left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end else if (send) begin
			bytes_q <= {CHAR_NUL, bytes_q[2], bytes_q[1]};
		end
	end

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(send && !last_of_run) |=> out_valid)
		else $error("burst ended before its last byte");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(send && last_of_run && !load) |=> !out_valid)
		else $error("byte presented after the last one of a burst");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !load)
		else $error("new burst loaded over a pending byte");

endmodule

`default_nettype wire
